@@ design/arw_pkg.sv @@
// Package for the anti-replay window check.
// Holds the fixed field widths, the verdict codes and the queue depth.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package arw_pkg;

   localparam int SEQ_IN_WIDTH  = 32;
   localparam int VERDICT_WIDTH = 2;
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [VERDICT_WIDTH-1:0] {
      VERDICT_ACCEPT    = 2'd0,
      VERDICT_TOO_OLD   = 2'd1,
      VERDICT_DUPLICATE = 2'd2
   } verdict_type;

endpackage

`default_nettype wire

@@ design/arw_intake.sv @@
// Front end: takes request beats, sizes the sequence number to SEQ_WIDTH
// and holds them in a two-entry queue for the window engine.
// Depends on arw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arw_intake
   import arw_pkg::*;
#(
   parameter int SEQ_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [SEQ_IN_WIDTH-1:0] req_seq,
   output logic                         q_valid,
   input  wire logic                    q_ready,
   output logic [SEQ_WIDTH-1:0]         q_seq
);

   logic [SEQ_WIDTH-1:0]   seq_norm;
   logic [SEQ_WIDTH-1:0]   slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                   push, pop;

   generate
      if (SEQ_WIDTH <= SEQ_IN_WIDTH) begin : g_trunc
         assign seq_norm = req_seq[SEQ_WIDTH-1:0];
      end else begin : g_ext
         assign seq_norm = {{(SEQ_WIDTH-SEQ_IN_WIDTH){1'b0}}, req_seq};
      end
   endgenerate

   assign req_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_valid   = (count_ff != '0);
   assign q_seq     = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= seq_norm;
      end
   end

endmodule

`default_nettype wire

@@ design/arw_engine.sv @@
// Back end: window base, seen bitmap and the verdict output register.
// One queued number is checked and the window updated per cycle, unless a held verdict stalls.
// Depends on arw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module arw_engine
   import arw_pkg::*;
#(
   parameter int WINDOW_SIZE = 256,
   parameter int SEQ_WIDTH   = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   output logic                          q_ready,
   input  wire logic [SEQ_WIDTH-1:0]     q_seq,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [VERDICT_WIDTH-1:0]      rsp_verdict,
   output logic [SEQ_WIDTH-1:0]          window_base
);

   localparam int AW = $clog2(WINDOW_SIZE);
   localparam logic [SEQ_WIDTH-1:0] WIN_S   = SEQ_WIDTH'(WINDOW_SIZE);
   localparam logic [SEQ_WIDTH-1:0] FAR_S   = SEQ_WIDTH'(2 * WINDOW_SIZE - 1);
   localparam logic [AW-1:0]        TOP_POS = AW'(WINDOW_SIZE - 1);

   logic [SEQ_WIDTH-1:0]   base_ff, base_in;
   logic [WINDOW_SIZE-1:0] map_ff, map_in;
   logic                   out_valid_ff, out_valid_in;
   verdict_type            verdict_ff, verdict_in;

   logic                   take;
   logic [SEQ_WIDTH-1:0]   offset;
   logic [SEQ_WIDTH-1:0]   adv_full;
   logic [AW-1:0]          adv;
   logic                   too_old, past_top, far;
   logic [WINDOW_SIZE-1:0] map_moved;
   logic [AW-1:0]          pos;
   logic                   dup;

   assign q_ready     = !out_valid_ff || rsp_ready;
   assign take        = q_valid && q_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_verdict = verdict_ff;
   assign window_base = base_ff;

   always_comb begin
      offset   = q_seq - base_ff;
      too_old  = (q_seq < base_ff);
      past_top = (offset >= WIN_S);
      far      = (offset >= FAR_S);
      adv_full = offset - WIN_S + SEQ_WIDTH'(1);
      adv      = adv_full[AW-1:0];

      if (far) begin
         map_moved = '0;
         pos       = '0;
      end else if (past_top) begin
         map_moved = map_ff >> adv;
         pos       = TOP_POS;
      end else begin
         map_moved = map_ff;
         pos       = offset[AW-1:0];
      end
      dup = map_moved[pos];

      base_in      = base_ff;
      map_in       = map_ff;
      out_valid_in = out_valid_ff;
      verdict_in   = verdict_ff;

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (take) begin
         out_valid_in = 1'b1;
         if (too_old) begin
            verdict_in = VERDICT_TOO_OLD;
         end else begin
            if (far) begin
               base_in = q_seq;
            end else if (past_top) begin
               base_in = base_ff + adv_full;
            end
            if (dup) begin
               verdict_in = VERDICT_DUPLICATE;
               map_in     = map_moved;
            end else begin
               verdict_in = VERDICT_ACCEPT;
               map_in     = map_moved | (WINDOW_SIZE'(1) << pos);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         map_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         map_ff       <= map_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff <= verdict_in;
   end

endmodule

`default_nettype wire

@@ design/anti_replay_window_check.sv @@
// Anti-replay window check, top level.
// Request channel (req_valid/req_ready/req_seq) takes one 32-bit sequence
// number per beat; response channel (rsp_valid/rsp_ready/rsp_verdict) returns
// one verdict per request, in order: 0 accept, 1 too old, 2 duplicate.
// Throughput: one beat per cycle sustained while rsp_ready stays high. Each
// accepted request passes through a queue slot, then the verdict register,
// before its response is valid. The window engine computes the new base and
// the new WINDOW_SIZE-bit bitmap (barrel shift plus bit test) in combinational
// logic ahead of its registers.
// Reset (synchronous, active high) clears the window base and the bitmap and
// empties the queue; a request may be taken the cycle after reset drops.
// When the receiver stalls, the verdict register holds, the engine stops
// pulling and the two-entry queue keeps taking requests until full, then
// req_ready drops.
// Depends on arw_pkg, arw_intake, arw_engine.
`timescale 1ns / 1ps
`default_nettype none

module anti_replay_window_check
   import arw_pkg::*;
#(
   parameter int WINDOW_SIZE = 256,
   parameter int SEQ_WIDTH   = 32
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [SEQ_IN_WIDTH-1:0]  req_seq,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [VERDICT_WIDTH-1:0]      rsp_verdict
);

   logic                 q_valid;
   logic                 q_ready;
   logic [SEQ_WIDTH-1:0] q_seq;
   logic [SEQ_WIDTH-1:0] window_base;

   arw_intake #(
      .SEQ_WIDTH (SEQ_WIDTH)
   ) u_intake (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_seq   (req_seq),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_seq     (q_seq)
   );

   arw_engine #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .SEQ_WIDTH   (SEQ_WIDTH)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_seq       (q_seq),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_verdict (rsp_verdict),
      .window_base (window_base)
   );

   // base only moves up
   a_base_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> window_base >= $past(window_base))
      else $error("window base moved down");

   // a queued beat stays queued until the engine takes it
   a_queue_holds: assert property (@(posedge clock) disable iff (reset)
      q_valid && !q_ready |=> q_valid && $stable(q_seq))
      else $error("queued beat lost while engine stalled");

   // verdict code 3 is never produced
   a_verdict_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_verdict != 2'd3)
      else $error("illegal verdict code");

endmodule

`default_nettype wire

@@ dv/tb_anti_replay_window_check.sv @@
// Testbench for anti_replay_window_check: directed and random sequence numbers,
// in-order verdict prediction and beat-by-beat checking with random stalls.
// Depends on arw_pkg and the anti_replay_window_check RTL.
`timescale 1ns / 1ps

module tb_anti_replay_window_check;
   import arw_pkg::*;

   localparam int WIN_SIZE   = 256;
   localparam int RAND_SEGS  = 4;
   localparam int SEG_ITEMS  = 325;
   localparam int HOLD_LEN   = 80;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   logic [SEQ_IN_WIDTH-1:0]   req_seq     = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b0;
   logic [VERDICT_WIDTH-1:0]  rsp_verdict;

   bit [31:0]        seq_backlog[$];
   verdict_type      verdicts_due[$];
   bit [31:0]        window_base_m;
   bit [WIN_SIZE-1:0] seen_marks;
   int               beats_sent   = 0;
   int               verdicts_got = 0;
   int               fail_count   = 0;
   int               hold_cnt     = 0;
   bit               held_once    = 1'b0;

   anti_replay_window_check #(
      .WINDOW_SIZE(WIN_SIZE),
      .SEQ_WIDTH  (32)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_seq    (req_seq),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_verdict(rsp_verdict)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // window update and verdict for one accepted sequence number
   function automatic verdict_type judge_seq(bit [31:0] seq);
      bit [63:0] offset;
      bit [63:0] advance;
      if (seq < window_base_m) return VERDICT_TOO_OLD;
      offset = 64'(seq) - 64'(window_base_m);
      if (offset >= WIN_SIZE) begin
         advance = offset - WIN_SIZE + 1;
         if (advance >= WIN_SIZE) begin
            seen_marks    = '0;
            window_base_m = seq;
            offset        = 0;
         end else begin
            seen_marks    = seen_marks >> advance;
            window_base_m = window_base_m + advance[31:0];
            offset        = WIN_SIZE - 1;
         end
      end
      if (seen_marks[offset]) return VERDICT_DUPLICATE;
      seen_marks[offset] = 1'b1;
      return VERDICT_ACCEPT;
   endfunction

   function automatic bit quiet_stretch(int n);
      return n >= 500 && n < 700;
   endfunction

   initial begin
      bit [63:0] cursor;
      bit [31:0] recent[$];
      bit [31:0] s;
      int        pick;
      bit [31:0] seg_lo[RAND_SEGS];
      bit [31:0] seg_hi[RAND_SEGS];
      seg_lo = '{32'h0000_1000, 32'h4000_0000, 32'h8000_0000, 32'hC000_0000};
      seg_hi = '{32'h3FFF_0000, 32'h7FFF_0000, 32'hBFFF_0000, 32'hEFFF_0000};
      window_base_m = '0;
      seen_marks    = '0;
      // directed: duplicates, too old, near and far jumps
      seq_backlog = '{0, 0, 255, 254, 256, 0, 255, 1, 511, 256,
                      767, 767, 766, 1022, 1023, 1279, 1279, 1024};
      cursor = 1279;
      for (int g = 0; g < RAND_SEGS; g++) begin
         cursor = $urandom_range(seg_hi[g], seg_lo[g]);
         recent.delete();
         for (int k = 0; k < SEG_ITEMS; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
               s = cursor + $urandom_range(300, 0) - 40;
               cursor = cursor + $urandom_range(8, 0);
            end else if (pick < 65 && recent.size() > 0) begin
               s = recent[$urandom_range(recent.size() - 1, 0)];
            end else if (pick < 75) begin
               s = $urandom_range(cursor[31:0], 0);
            end else if (pick < 90) begin
               s = cursor + WIN_SIZE + $urandom_range(WIN_SIZE - 1, 0);
               cursor = s;
            end else begin
               s = cursor + $urandom_range(100000, 2 * WIN_SIZE);
               cursor = s;
            end
            seq_backlog.push_back(s);
            recent.push_back(s);
            if (recent.size() > 16) void'(recent.pop_front());
         end
      end
      // top of the number space last, since nothing passes after it
      seq_backlog.push_back(32'hFFFF_FF00);
      seq_backlog.push_back(32'hFFFF_FFFF);
      seq_backlog.push_back(32'hFFFF_FFFF);
      seq_backlog.push_back(32'hFFFF_FEFF);
      seq_backlog.push_back(32'h0000_0000);
      seq_backlog.push_back(32'hFFFF_FFFE);
   end

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            verdicts_due.push_back(judge_seq(req_seq));
            beats_sent++;
         end
         if (!req_valid || req_ready) begin
            if (seq_backlog.size() > 0 &&
                (quiet_stretch(beats_sent) || $urandom_range(0, 99) >= 23)) begin
               req_valid <= 1'b1;
               req_seq   <= seq_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and ready control
   always @(posedge clock) begin
      verdict_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (verdicts_due.size() == 0) begin
               $display("%0t: unexpected verdict beat, got %0d", $time, rsp_verdict);
               fail_count++;
            end else begin
               want = verdicts_due.pop_front();
               if (rsp_verdict !== want) begin
                  $display("%0t: verdict mismatch, expected %0d got %0d",
                           $time, want, rsp_verdict);
                  fail_count++;
               end
            end
            verdicts_got++;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else if (!held_once && verdicts_got >= 150) begin
            held_once = 1'b1;
            hold_cnt  = HOLD_LEN;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_stretch(verdicts_got) || $urandom_range(0, 99) >= 23;
         end
      end
   end

   initial begin
      @(negedge reset);
      do @(negedge clock);
      while (seq_backlog.size() != 0 || req_valid || verdicts_due.size() != 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && verdicts_due.size() == 0) begin
         $display("tb_anti_replay_window_check OK");
      end else begin
         $display("tb_anti_replay_window_check NOT OK");
      end
      $finish;
   end

   initial begin
      #2ms;
      $display("tb_anti_replay_window_check NOT OK");
      $finish;
   end

endmodule

@@ anti_replay_window_check.f @@
design/arw_pkg.sv
design/arw_intake.sv
design/arw_engine.sv
design/anti_replay_window_check.sv
dv/tb_anti_replay_window_check.sv
